// ===== sv/rbnh_pkg.sv =====
// Shared widths, register indexes, reset values and control types for the ray/box hit block.
`timescale 1ns / 1ps

package rbnh_pkg;

    localparam int ID_BITS_DEF    = 8;
    localparam int COORD_BITS_DEF = 32;

    localparam int INV_BITS      = 32;
    localparam int DIST_BITS     = 32;
    localparam int RANGE_BITS    = 31;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int FRAC_BITS     = 16;
    // slab times are clamped to +-2^40, which needs 42 signed bits
    localparam int TIME_BITS     = 42;

    localparam logic signed [TIME_BITS-1:0] T_CAP     = 42'sh100_0000_0000;
    localparam logic signed [TIME_BITS-1:0] T_CAP_NEG = -T_CAP;

    localparam logic signed [DIST_BITS-1:0] NO_HIT = -32'sd65536;

    localparam logic [INV_BITS-1:0]   INV_RESET   = 32'd65536;
    localparam logic [DIST_BITS-1:0]  BLOCK_RESET = 32'hFFFF_0000;
    localparam logic [RANGE_BITS-1:0] RANGE_RESET = 31'd524288;

    localparam logic [CFG_ADDR_BITS-1:0] REG_INV_DIR_X    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INV_DIR_Y    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INV_DIR_Z    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BLOCK_HIT    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_RANGE    = 3'd4;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic ok;
    } slab_res_t;

endpackage

// ===== sv/ray_box_nearest_hit.sv =====
// Nearest ray/box hit over a stream of boxes, one result per query.
// The result reaches m_tvalid after the query's last box passes the input and slab registers.
// Throughput: one box per cycle unless stalled; the per-box slab test is fully pipelined
// and only the running-minimum compare in the final stage loops back on itself.
// Input stalls only while a finished result waits and another query end reaches the last stage.
// Reset (aresetn low, synchronous) clears pipeline valids and query state and reloads config reset values.
`timescale 1ns / 1ps

module ray_box_nearest_hit import rbnh_pkg::*; #(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_DATA_BITS = ((9 * COORD_BITS + ID_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((ID_BITS + DIST_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // box requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // origin_x, origin_y, origin_z, box_lo_x, box_lo_y, box_lo_z,
    // box_hi_x, box_hi_y, box_hi_z, box_id
    input  logic [S_DATA_BITS-1:0]   s_tdata,
    input  logic                     s_tlast,   // last_box
    // results
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // hit_id, hit_dist
    output logic [M_DATA_BITS-1:0]   m_tdata,
    output logic                     m_tuser,   // entity_hit
    // config writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_wr_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data
);

    logic [2:0][INV_BITS-1:0]    inv_reg;
    logic signed [DIST_BITS-1:0] block_reg;
    logic [RANGE_BITS-1:0]       max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg       <= {3{INV_RESET}};
            block_reg     <= BLOCK_RESET;
            max_range_reg <= RANGE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_INV_DIR_X: inv_reg[0]    <= cfg_wr_data;
                REG_INV_DIR_Y: inv_reg[1]    <= cfg_wr_data;
                REG_INV_DIR_Z: inv_reg[2]    <= cfg_wr_data;
                REG_BLOCK_HIT: block_reg     <= cfg_wr_data;
                REG_MAX_RANGE: max_range_reg <= cfg_wr_data[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic stall;

    // input register
    beat_ctl_t                  in_ctl_reg;
    logic [2:0][COORD_BITS-1:0] origin_reg, lo_reg, hi_reg;
    logic [ID_BITS-1:0]         id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
        end else if (adv) begin
            in_ctl_reg <= '{valid: s_tvalid, last: s_tlast};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int ax = 0; ax < 3; ax++) begin
                origin_reg[ax] <= s_tdata[ax * COORD_BITS +: COORD_BITS];
                lo_reg[ax]     <= s_tdata[(3 + ax) * COORD_BITS +: COORD_BITS];
                hi_reg[ax]     <= s_tdata[(6 + ax) * COORD_BITS +: COORD_BITS];
            end
            id_reg <= s_tdata[9 * COORD_BITS +: ID_BITS];
        end
    end

    slab_res_t                   res;
    logic [ID_BITS-1:0]          res_id;
    logic signed [TIME_BITS-1:0] res_dt;

    rbnh_slab #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_slab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (in_ctl_reg),
        .in_id   (id_reg),
        .origin  (origin_reg),
        .box_lo  (lo_reg),
        .box_hi  (hi_reg),
        .inv_dir (inv_reg),
        .res     (res),
        .res_id  (res_id),
        .res_dt  (res_dt)
    );

    // running nearest hit
    logic signed [DIST_BITS-1:0] best_dist_reg;
    logic [ID_BITS-1:0]          best_id_reg;
    logic                        best_found_reg;
    logic                        in_query_reg;

    logic signed [DIST_BITS-1:0] cur_dist;
    logic [ID_BITS-1:0]          cur_id;
    logic                        cur_found;
    logic signed [TIME_BITS-1:0] range_ext;
    logic                        take;
    logic signed [DIST_BITS-1:0] best_dist_next;
    logic [ID_BITS-1:0]          best_id_next;
    logic                        best_found_next;

    always_comb begin
        if (in_query_reg) begin
            cur_dist  = best_dist_reg;
            cur_id    = best_id_reg;
            cur_found = best_found_reg;
        end else begin
            // query start: seed from the block distance, any negative means no block hit
            cur_dist  = (block_reg < 0) ? NO_HIT : block_reg;
            cur_id    = '0;
            cur_found = 1'b0;
        end
        range_ext = signed'(TIME_BITS'(max_range_reg));
        // ties keep the earlier box or the block
        take = res.valid && res.ok && (res_dt <= range_ext)
               && (cur_dist < 0 || res_dt < TIME_BITS'(cur_dist));
        best_dist_next  = take ? res_dt[DIST_BITS-1:0] : cur_dist;
        best_id_next    = take ? res_id : cur_id;
        best_found_next = take || cur_found;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg  <= NO_HIT;
            best_id_reg    <= '0;
            best_found_reg <= 1'b0;
            in_query_reg   <= 1'b0;
        end else if (adv && res.valid) begin
            best_dist_reg  <= best_dist_next;
            best_id_reg    <= best_id_next;
            best_found_reg <= best_found_next;
            in_query_reg   <= !res.last;
        end
    end

    // output register
    logic                        m_valid_reg;
    logic                        out_hit_reg;
    logic [ID_BITS-1:0]          out_id_reg;
    logic [DIST_BITS-1:0]        out_dist_reg;

    assign stall    = res.valid && res.last && m_valid_reg && !m_tready;
    assign adv      = !stall;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && res.valid && res.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid && res.last) begin
            out_hit_reg  <= best_found_next;
            out_id_reg   <= best_id_next;
            out_dist_reg <= best_dist_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = M_DATA_BITS'({out_dist_reg, out_id_reg});

endmodule

// ===== sv/rbnh_slab.sv =====
// Pipelined three-axis slab test: corner differences, products, clamped times, slab intersection.
`timescale 1ns / 1ps

module rbnh_slab import rbnh_pkg::*; #(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  beat_ctl_t                          in_ctl,
    input  logic [ID_BITS-1:0]                 in_id,
    input  logic [2:0][COORD_BITS-1:0]         origin,
    input  logic [2:0][COORD_BITS-1:0]         box_lo,
    input  logic [2:0][COORD_BITS-1:0]         box_hi,
    input  logic [2:0][INV_BITS-1:0]           inv_dir,
    output slab_res_t                          res,
    output logic [ID_BITS-1:0]                 res_id,
    output logic signed [TIME_BITS-1:0]        res_dt
);

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + INV_BITS;
    localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
    localparam int EXT_BITS   = (SHIFT_BITS > TIME_BITS) ? SHIFT_BITS : TIME_BITS;

    // floor(p / 2^16), clamped to +-2^40
    function automatic logic signed [TIME_BITS-1:0] to_time(
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [SHIFT_BITS-1:0] sh;
        logic signed [EXT_BITS-1:0]   ext;
        begin
            sh  = p[PROD_BITS-1:FRAC_BITS];
            ext = EXT_BITS'(sh);
            if (ext > EXT_BITS'(T_CAP)) begin
                return T_CAP;
            end else if (ext < EXT_BITS'(T_CAP_NEG)) begin
                return T_CAP_NEG;
            end else begin
                return ext[TIME_BITS-1:0];
            end
        end
    endfunction

    beat_ctl_t ctl2_reg, ctl3_reg, ctl4_reg;
    logic [ID_BITS-1:0] id2_reg, id3_reg, id4_reg, id5_reg;

    logic signed [DIFF_BITS-1:0] dlo_reg [3];
    logic signed [DIFF_BITS-1:0] dhi_reg [3];
    logic [2:0] lt2_reg, gt2_reg, lt3_reg, gt3_reg;

    logic signed [PROD_BITS-1:0] plo_reg [3];
    logic signed [PROD_BITS-1:0] phi_reg [3];

    logic signed [TIME_BITS-1:0] tmin_reg [3];
    logic signed [TIME_BITS-1:0] tmax_reg [3];
    logic signed [TIME_BITS-1:0] tmin_next [3];
    logic signed [TIME_BITS-1:0] tmax_next [3];

    logic                        ok_next;
    logic signed [TIME_BITS-1:0] dt_next;
    slab_res_t                   res_reg;
    logic signed [TIME_BITS-1:0] dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            res_reg  <= '0;
        end else if (adv) begin
            ctl2_reg <= in_ctl;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            res_reg  <= '{valid: ctl4_reg.valid, last: ctl4_reg.last, ok: ok_next};
        end
    end

    // time selection per axis, from the two clamped products
    always_comb begin
        logic signed [TIME_BITS-1:0] tl, th;
        for (int ax = 0; ax < 3; ax++) begin
            tl = to_time(plo_reg[ax]);
            th = to_time(phi_reg[ax]);
            if (lt3_reg[ax]) begin
                tmin_next[ax] = tl;
                tmax_next[ax] = th;
            end else if (gt3_reg[ax]) begin
                tmin_next[ax] = th;
                tmax_next[ax] = tl;
            end else begin
                // origin inside the slab
                tmin_next[ax] = '0;
                tmax_next[ax] = inv_dir[ax][INV_BITS-1] ? tl : th;
            end
        end
    end

    // slab intersection over the three axes; first axis seeds the exit time
    always_comb begin
        logic signed [TIME_BITS-1:0] mx;
        ok_next = 1'b1;
        dt_next = '0;
        mx      = tmax_reg[0];
        for (int ax = 0; ax < 3; ax++) begin
            if (tmin_reg[ax] < 0 || tmin_reg[ax] > mx || tmax_reg[ax] < dt_next) begin
                ok_next = 1'b0;
            end
            if (tmin_reg[ax] > dt_next) begin
                dt_next = tmin_reg[ax];
            end
            if (tmax_reg[ax] < mx) begin
                mx = tmax_reg[ax];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            id2_reg <= in_id;
            id3_reg <= id2_reg;
            id4_reg <= id3_reg;
            id5_reg <= id4_reg;
            lt3_reg <= lt2_reg;
            gt3_reg <= gt2_reg;
            dt_reg  <= dt_next;
            for (int ax = 0; ax < 3; ax++) begin
                dlo_reg[ax] <= DIFF_BITS'($signed(box_lo[ax])) - DIFF_BITS'($signed(origin[ax]));
                dhi_reg[ax] <= DIFF_BITS'($signed(box_hi[ax])) - DIFF_BITS'($signed(origin[ax]));
                lt2_reg[ax] <= $signed(origin[ax]) < $signed(box_lo[ax]);
                gt2_reg[ax] <= $signed(origin[ax]) > $signed(box_hi[ax]);
                plo_reg[ax] <= PROD_BITS'(dlo_reg[ax]) * PROD_BITS'($signed(inv_dir[ax]));
                phi_reg[ax] <= PROD_BITS'(dhi_reg[ax]) * PROD_BITS'($signed(inv_dir[ax]));
                tmin_reg[ax] <= tmin_next[ax];
                tmax_reg[ax] <= tmax_next[ax];
            end
        end
    end

    assign res    = res_reg;
    assign res_id = id5_reg;
    assign res_dt = dt_reg;

endmodule

// ===== sv/rbnh_checker.sv =====
// Port-level checks for the ray/box hit block, bound to its top level.
`timescale 1ns / 1ps

module rbnh_checker import rbnh_pkg::*; #(
    parameter int ID_BITS = ID_BITS_DEF,
    localparam int M_DATA_BITS = ((ID_BITS + DIST_BITS + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata,
    input logic                   m_tuser
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input only backs up behind a result that is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

    a_miss_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[ID_BITS-1:0] == '0)
        else $error("hit_id nonzero without an entity hit");

    a_hit_dist_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[ID_BITS+DIST_BITS-1])
        else $error("entity hit with negative distance");

    a_neg_is_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ID_BITS+DIST_BITS-1] |-> m_tdata[ID_BITS +: DIST_BITS] == NO_HIT)
        else $error("negative distance other than the no-hit value");

endmodule

bind ray_box_nearest_hit rbnh_checker #(.ID_BITS(ID_BITS)) u_rbnh_checker (.*);
